[rtl/hte_pkg.sv]
// hte_pkg: shared constants, word layout and control structs for the
// table-driven Huffman encoder. No dependencies.
`timescale 1ns / 1ps

package hte_pkg;

   // default sizing
   localparam int MAX_CODE_BITS_DEF = 256;
   localparam int SYMBOLS_DEF       = 256;

   // code chunks
   localparam int CHUNK_BITS    = 64;
   localparam int CHUNK_IDX_W   = 2;
   localparam int CHUNK_LEFT_W  = 7;    // holds 0..CHUNK_BITS
   localparam int BYTE_W        = 8;
   localparam int BYTE_CNT_W    = 3;
   localparam int TAKE_W        = 4;    // holds 0..BYTE_W

   // input word layout (tdata), lowest bit first
   localparam int SYM_IN_W      = 8;
   localparam int LEN_IN_W      = 9;
   localparam int SYM_LSB       = 0;
   localparam int LEN_LSB       = SYM_LSB + SYM_IN_W;
   localparam int CIDX_LSB      = LEN_LSB + LEN_IN_W;
   localparam int CHUNK_LSB     = CIDX_LSB + CHUNK_IDX_W;
   localparam int REQ_FIELDS_W  = CHUNK_LSB + CHUNK_BITS;
   localparam int REQ_TDATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;

   // command kinds carried in req_tuser
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic wr_en;       // table write of a load word
      logic rd_start;    // encode accepted: read length and first chunk
      logic rd_next;     // read the next chunk of the code
      logic step_en;     // run one packing step
      logic load_len;    // step takes the length from the length RAM
      logic load_chunk;  // step takes the chunk from the code RAM
   } hte_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_load;
      logic sym_ok;
      logic stall;        // finished byte but output register still full
      logic rem_done;     // no code bits left after this step
      logic chunk_empty;  // current chunk used up after this step
   } hte_sts_type;

endpackage

[rtl/hte_ram.sv]
// hte_ram: generic simple dual-port RAM, registered read with read enable.
// No dependencies.
`timescale 1ns / 1ps

module hte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/hte_ctrl.sv]
// hte_ctrl: sequencer for the Huffman encoder; accepts words and steps the
// packing datapath. Depends on hte_pkg.
`timescale 1ns / 1ps

module hte_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  hte_pkg::hte_sts_type sts,
   output hte_pkg::hte_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_PACK
   } state_type;

   state_type state_ff, state_in;
   logic      rdy_ff, rdy_in;
   logic      load_len_ff, load_len_in;
   logic      load_chunk_ff, load_chunk_in;

   always_comb begin
      state_in      = state_ff;
      rdy_in        = rdy_ff;
      load_len_in   = load_len_ff;
      load_chunk_in = load_chunk_ff;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && rdy_ff) begin
               if (sts.is_load) begin
                  cmd.wr_en = sts.sym_ok;
               end else if (sts.sym_ok) begin
                  cmd.rd_start  = 1'b1;
                  state_in      = ST_PACK;
                  rdy_in        = 1'b0;
                  load_len_in   = 1'b1;
                  load_chunk_in = 1'b1;
               end
            end
         end
         ST_PACK: begin
            cmd.step_en    = 1'b1;
            cmd.load_len   = load_len_ff;
            cmd.load_chunk = load_chunk_ff;
            if (!sts.stall) begin
               load_len_in   = 1'b0;
               load_chunk_in = 1'b0;
               if (sts.rem_done) begin
                  state_in = ST_IDLE;
                  rdy_in   = 1'b1;
               end else if (sts.chunk_empty) begin
                  cmd.rd_next   = 1'b1;
                  load_chunk_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            rdy_in   = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rdy_ff        <= 1'b1;
         load_len_ff   <= 1'b0;
         load_chunk_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rdy_ff        <= rdy_in;
         load_len_ff   <= load_len_in;
         load_chunk_ff <= load_chunk_in;
      end
   end

   assign req_tready = rdy_ff;

endmodule

[rtl/hte_datapath.sv]
// hte_datapath: code/length tables, bit packer and output register of the
// Huffman encoder. Depends on hte_pkg and hte_ram.
`timescale 1ns / 1ps

module hte_datapath #(
   parameter int MAX_CODE_BITS = hte_pkg::MAX_CODE_BITS_DEF,
   parameter int SYMBOLS       = hte_pkg::SYMBOLS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [hte_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   output logic [hte_pkg::BYTE_W-1:0]      rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  hte_pkg::hte_cmd_type            cmd,
   output hte_pkg::hte_sts_type            sts
);

   localparam int SYM_W  = $clog2(SYMBOLS);
   localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);
   localparam int CADR_W = SYM_W + hte_pkg::CHUNK_IDX_W;
   localparam logic [hte_pkg::LEN_IN_W-1:0] SYM_LIMIT = hte_pkg::LEN_IN_W'(SYMBOLS);
   localparam logic [hte_pkg::LEN_IN_W-1:0] LEN_LIMIT = hte_pkg::LEN_IN_W'(MAX_CODE_BITS);

   // input word fields
   logic [hte_pkg::SYM_IN_W-1:0]    in_sym;
   logic [hte_pkg::LEN_IN_W-1:0]    in_len;
   logic [hte_pkg::CHUNK_IDX_W-1:0] in_cidx;
   logic [hte_pkg::CHUNK_BITS-1:0]  in_chunk;
   logic [LEN_W-1:0]                len_sat;

   assign in_sym   = req_tdata[hte_pkg::SYM_LSB +: hte_pkg::SYM_IN_W];
   assign in_len   = req_tdata[hte_pkg::LEN_LSB +: hte_pkg::LEN_IN_W];
   assign in_cidx  = req_tdata[hte_pkg::CIDX_LSB +: hte_pkg::CHUNK_IDX_W];
   assign in_chunk = req_tdata[hte_pkg::CHUNK_LSB +: hte_pkg::CHUNK_BITS];
   assign len_sat  = (in_len > LEN_LIMIT) ? LEN_W'(MAX_CODE_BITS) : in_len[LEN_W-1:0];

   // encode context
   logic [SYM_W-1:0]                sym_ff, sym_in;
   logic [hte_pkg::CHUNK_IDX_W-1:0] cidx_ff, cidx_in;

   // packer state
   logic [hte_pkg::CHUNK_BITS-1:0]   sh_ff, sh_in;
   logic [hte_pkg::CHUNK_LEFT_W-1:0] left_ff, left_in;
   logic [LEN_W-1:0]                 rem_ff, rem_in;
   logic [hte_pkg::BYTE_W-1:0]       acc_ff, acc_in;
   logic [hte_pkg::BYTE_CNT_W-1:0]   cnt_ff, cnt_in;

   // output register
   logic                       out_valid_ff, out_valid_in;
   logic [hte_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic                       out_last_ff, out_last_in;

   // table RAMs
   logic [CADR_W-1:0]              code_rd_addr;
   logic [hte_pkg::CHUNK_BITS-1:0] code_q;
   logic [LEN_W-1:0]               len_q;

   hte_ram #(
      .WIDTH (hte_pkg::CHUNK_BITS),
      .DEPTH (SYMBOLS * (1 << hte_pkg::CHUNK_IDX_W))
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr ({in_sym[SYM_W-1:0], in_cidx}),
      .wr_data (in_chunk),
      .rd_en   (cmd.rd_start | cmd.rd_next),
      .rd_addr (code_rd_addr),
      .rd_data (code_q)
   );

   hte_ram #(
      .WIDTH (LEN_W),
      .DEPTH (SYMBOLS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (in_sym[SYM_W-1:0]),
      .wr_data (len_sat),
      .rd_en   (cmd.rd_start),
      .rd_addr (in_sym[SYM_W-1:0]),
      .rd_data (len_q)
   );

   assign code_rd_addr = cmd.rd_start ? {in_sym[SYM_W-1:0], hte_pkg::CHUNK_IDX_W'(0)}
                                      : {sym_ff, cidx_ff + hte_pkg::CHUNK_IDX_W'(1)};

   // one packing step: move up to a byte's worth of code bits into acc
   logic [hte_pkg::CHUNK_BITS-1:0]   sh_cur;
   logic [hte_pkg::CHUNK_LEFT_W-1:0] left_cur;
   logic [LEN_W-1:0]                 rem_cur;
   logic [hte_pkg::TAKE_W-1:0]       take;
   logic [hte_pkg::BYTE_W-1:0]       top_bits;
   logic [hte_pkg::BYTE_W-1:0]       acc_new;
   logic [hte_pkg::TAKE_W-1:0]       cnt_sum;
   logic [LEN_W-1:0]                 rem_new;
   logic [hte_pkg::CHUNK_LEFT_W-1:0] left_new;
   logic                             byte_done;
   logic                             commit;

   always_comb begin
      sh_cur   = cmd.load_chunk ? code_q : sh_ff;
      left_cur = cmd.load_chunk ? hte_pkg::CHUNK_LEFT_W'(hte_pkg::CHUNK_BITS) : left_ff;
      rem_cur  = cmd.load_len ? len_q : rem_ff;

      take = hte_pkg::TAKE_W'(hte_pkg::BYTE_W) - hte_pkg::TAKE_W'(cnt_ff);
      if (rem_cur < LEN_W'(take)) begin
         take = rem_cur[hte_pkg::TAKE_W-1:0];
      end
      if (left_cur < hte_pkg::CHUNK_LEFT_W'(take)) begin
         take = left_cur[hte_pkg::TAKE_W-1:0];
      end

      top_bits  = sh_cur[hte_pkg::CHUNK_BITS-1 -: hte_pkg::BYTE_W]
                  & ~(8'hFF >> take);
      acc_new   = acc_ff | (top_bits >> cnt_ff);
      cnt_sum   = hte_pkg::TAKE_W'(cnt_ff) + take;
      byte_done = cnt_sum[hte_pkg::TAKE_W-1];
      rem_new   = rem_cur - LEN_W'(take);
      left_new  = left_cur - hte_pkg::CHUNK_LEFT_W'(take);
   end

   assign sts.is_load     = (req_tuser == hte_pkg::CMD_LOAD);
   assign sts.sym_ok      = ({1'b0, in_sym} < SYM_LIMIT);
   assign sts.stall       = cmd.step_en & byte_done & out_valid_ff & ~rsp_tready;
   assign sts.rem_done    = (rem_new == '0);
   assign sts.chunk_empty = (left_new == '0);

   assign commit = cmd.step_en & ~sts.stall;

   always_comb begin
      sym_in       = sym_ff;
      cidx_in      = cidx_ff;
      sh_in        = sh_ff;
      left_in      = left_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;

      if (cmd.rd_start) begin
         sym_in  = in_sym[SYM_W-1:0];
         cidx_in = '0;
      end
      if (cmd.rd_next) begin
         cidx_in = cidx_ff + hte_pkg::CHUNK_IDX_W'(1);
      end
      if (commit) begin
         sh_in   = sh_cur << take;
         left_in = left_new;
         rem_in  = rem_new;
         if (byte_done) begin
            acc_in       = '0;
            cnt_in       = '0;
            out_valid_in = 1'b1;
            out_byte_in  = acc_new;
            // no further byte once fewer than eight code bits remain
            out_last_in  = (rem_new < LEN_W'(hte_pkg::BYTE_W));
         end else begin
            acc_in = acc_new;
            cnt_in = cnt_sum[hte_pkg::BYTE_CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      cidx_ff     <= cidx_in;
      sh_ff       <= sh_in;
      left_ff     <= left_in;
      rem_ff      <= rem_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[rtl/huffman_table_encoder.sv]
// huffman_table_encoder: top level of the table-driven Huffman bit packer.
// Depends on hte_pkg, hte_ctrl, hte_datapath (and through it hte_ram).
`timescale 1ns / 1ps

// Usage
//   req channel: one word per command. req_tuser selects the kind: a load
//   word writes a symbol's code length and one 64-bit chunk of its code into
//   the tables; an encode word packs that symbol's code after the bits left
//   pending by earlier symbols. Load every chunk an encoded code needs first.
//   rsp channel: one word per completed byte, first code bit in bit 7;
//   rsp_tlast marks the final byte an encode produces. Loads and encodes
//   that finish no byte give no rsp word. Fewer than 8 leftover bits stay
//   pending; there is no flush.
//   Timing: a load writes the tables in the cycle it is accepted. An encode
//   first reads the length and first chunk, then runs one packing step per
//   cycle, stalls aside; a step stops at a byte boundary, a chunk boundary
//   or the code end. With p pending bits: max(1, ceil((p + len) / 8))
//   steps, plus one per chunk crossing when p is nonzero. A byte enters the
//   output register at the step that completes it, at the earliest in the
//   cycle after accept.
//   Stalls: the packer holds when a byte is done, the output register is full
//   and rsp_tready low; req_tready stays low until the running encode is done.
//   Reset: clears pending bits and control; tables stay undefined until
//   loaded.
module huffman_table_encoder #(
   parameter int MAX_CODE_BITS = hte_pkg::MAX_CODE_BITS_DEF,  // 8..256
   parameter int SYMBOLS       = hte_pkg::SYMBOLS_DEF         // 2..256
) (
   input  logic                            clock,
   input  logic                            reset,
   // request words
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] symbol, [16:8] code_len, [18:17] chunk_index,
   // [82:19] code_chunk, [87:83] zero
   input  logic [hte_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tuser,   // [0] cmd: 0 encode, 1 load
   // result words
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hte_pkg::BYTE_W-1:0]      rsp_tdata,   // [7:0] out_byte
   output logic                            rsp_tlast    // last_byte
);

   hte_pkg::hte_cmd_type cmd;
   hte_pkg::hte_sts_type sts;

   // sequencer: accept, then step the packer until the code is used up
   hte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // tables, packer and output register
   hte_datapath #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .SYMBOLS       (SYMBOLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
